/* rtl/lsar_pkg.sv */
`timescale 1ns / 1ps

package lsar_pkg;

  // request codes carried by an input item
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_OPEN  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  // register indexes on the configuration port (paddr[3:2])
  localparam logic [1:0] REG_RUN_SPEED   = 2'd0;
  localparam logic [1:0] REG_RAMP_PERIOD = 2'd1;
  localparam logic [1:0] REG_DUTY_STEP   = 2'd2;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // register reset values
  localparam logic [7:0] RUN_SPEED_RST   = 8'd200;
  localparam logic [9:0] RAMP_PERIOD_RST = 10'd10;
  localparam logic [7:0] DUTY_STEP_RST   = 8'd5;

  // elapsed time counter saturates here
  localparam logic [9:0] ELAPSED_MAX = 10'd1023;

endpackage

/* rtl/lsar_stream_if.sv */
`timescale 1ns / 1ps

// request channel: tick or open/close command with limit switch levels
interface lsar_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       open_limit;
  logic       close_limit;

  modport source (output valid, req_type, open_limit, close_limit, input ready);
  modport sink   (input valid, req_type, open_limit, close_limit, output ready);
endinterface

// result channel: drive outputs after each item
interface lsar_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_duty;
  logic       direction_pin;
  logic       moving;
  logic [7:0] target_speed;

  modport source (output valid, pwm_duty, direction_pin, moving, target_speed, input ready);
  modport sink   (input valid, pwm_duty, direction_pin, moving, target_speed, output ready);
endinterface

/* rtl/limit_switched_actuator_ramp.sv */
`timescale 1ns / 1ps

// Damper actuator drive with soft-start duty ramp and limit switch stop.
// in_req carries one item per request: a millisecond tick, or an open or
// close command together with the sampled limit switch levels. out_res
// returns one item per request with the duty, direction pin, moving flag
// and ramp target as they stand after that request.
// Three registers (run speed, ramp period, duty step) sit on the APB port
// at byte addresses 0, 4 and 8; change them only while no item is in flight.
// An accepted item passes through the input register and then the result
// register before it appears on out_res.
// Throughput: one item per cycle unless out_res stalls; the next-state logic
// (10-bit compares, 8-bit add/subtract, compares) sits between the two registers.
// Reset (rst_n low, synchronous) idles the drive, clears duty, target,
// direction and elapsed time, and loads the register defaults.
// When the receiver stalls, the result register holds its item and the input
// register takes one more; in_req.ready then drops until out_res drains.
module limit_switched_actuator_ramp (
  input  logic                              clk,
  input  logic                              rst_n,
  lsar_req_if.sink                          in_req,
  lsar_res_if.source                        out_res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lsar_pkg::PADDR_W-1:0]      paddr,
  input  logic [lsar_pkg::PDATA_W-1:0]      pwdata,
  output logic [lsar_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  // configuration registers
  logic [7:0] run_speed_r;
  logic [9:0] ramp_period_r;
  logic [7:0] duty_step_r;

  // input register
  logic       s1_valid_r;
  logic [1:0] s1_req_r;
  logic       s1_olim_r;
  logic       s1_clim_r;

  // drive state
  logic       run_r,      run_nxt;
  logic       dir_out_r,  dir_out_nxt;
  logic [7:0] target_r,   target_nxt;
  logic [7:0] duty_r,     duty_nxt;
  logic [9:0] elapsed_r,  elapsed_nxt;

  // result register
  logic       out_valid_r;

  logic       s1_adv;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic       cmd_open;
  logic       cmd_limit;
  logic [9:0] elapsed_inc;
  logic       ramp_due;
  logic [7:0] duty_diff;

  // pipeline handshake
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign out_res.valid = out_valid_r;

  // apb register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      lsar_pkg::REG_RUN_SPEED:   prdata = {24'd0, run_speed_r};
      lsar_pkg::REG_RAMP_PERIOD: prdata = {22'd0, ramp_period_r};
      lsar_pkg::REG_DUTY_STEP:   prdata = {24'd0, duty_step_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_speed_r   <= lsar_pkg::RUN_SPEED_RST;
      ramp_period_r <= lsar_pkg::RAMP_PERIOD_RST;
      duty_step_r   <= lsar_pkg::DUTY_STEP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lsar_pkg::REG_RUN_SPEED:   run_speed_r   <= pwdata[7:0];
        lsar_pkg::REG_RAMP_PERIOD: ramp_period_r <= pwdata[9:0];
        lsar_pkg::REG_DUTY_STEP:   duty_step_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ramp step arithmetic
  assign elapsed_inc = (elapsed_r == lsar_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + 10'd1;
  assign ramp_due    = (elapsed_inc >= ramp_period_r) && ((target_r != 8'd0) || (duty_r != 8'd0));
  assign duty_diff   = (duty_r > target_r) ? (duty_r - target_r) : (target_r - duty_r);

  // command decode
  assign cmd_open  = (s1_req_r == lsar_pkg::REQ_OPEN);
  assign cmd_limit = cmd_open ? s1_olim_r : s1_clim_r;

  // next drive state for the item in the input register
  always_comb begin
    run_nxt     = run_r;
    dir_out_nxt = dir_out_r;
    target_nxt  = target_r;
    duty_nxt    = duty_r;
    elapsed_nxt = elapsed_r;
    case (s1_req_r)
      lsar_pkg::REQ_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (ramp_due) begin
          elapsed_nxt = '0;
          if (duty_diff > duty_step_r) begin
            duty_nxt = (duty_r < target_r) ? duty_r + duty_step_r : duty_r - duty_step_r;
          end else begin
            duty_nxt = target_r;
          end
        end
      end
      lsar_pkg::REQ_OPEN, lsar_pkg::REQ_CLOSE: begin
        if (cmd_limit) begin
          // limit reached: stop a moving drive
          if (run_r) begin
            target_nxt  = '0;
            dir_out_nxt = 1'b0;
            run_nxt     = 1'b0;
          end
        end else if (!run_r) begin
          // limit clear and idle: start moving, zero speed drops the pin
          run_nxt     = 1'b1;
          target_nxt  = run_speed_r;
          dir_out_nxt = cmd_open && (run_speed_r != 8'd0);
        end
      end
      default: ;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
    if (in_req.ready && in_req.valid) begin
      s1_req_r  <= in_req.req_type;
      s1_olim_r <= in_req.open_limit;
      s1_clim_r <= in_req.close_limit;
    end
  end

  // drive state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      dir_out_r   <= 1'b0;
      target_r    <= '0;
      duty_r      <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        run_r     <= run_nxt;
        dir_out_r <= dir_out_nxt;
        target_r  <= target_nxt;
        duty_r    <= duty_nxt;
        elapsed_r <= elapsed_nxt;
      end
      if (!out_valid_r || out_res.ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
    if (s1_adv) begin
      out_res.pwm_duty      <= duty_nxt;
      out_res.direction_pin <= dir_out_nxt;
      out_res.moving        <= run_nxt;
      out_res.target_speed  <= target_nxt;
    end
  end

  // a zero target always leaves the direction pin low
  a_zero_target_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (target_r == 8'd0) |-> !dir_out_r)
    else $error("direction pin high with zero target");

  // an idle drive has no target
  a_idle_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> (target_r == 8'd0))
    else $error("idle drive with nonzero target");

  // full pipeline under stall refuses new items
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_res.ready) |-> !in_req.ready)
    else $error("input accepted while both stages are held");

  // a result leaving the input stage reports the updated state
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_res.pwm_duty == duty_r) && (out_res.target_speed == target_r)
               && (out_res.moving == run_r) && (out_res.direction_pin == dir_out_r))
    else $error("result register differs from drive state");

endmodule
